// File: rtl/lts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

  localparam int STAT_W    = 32;
  localparam int SUM_W     = 64;
  localparam int CPU_W     = 10;
  localparam int LOAD_W    = 24;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  // opcodes
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_CYCLE_MODE    = 2'd0;
  localparam logic [1:0] REG_CYCLES_PER_US = 2'd1;
  localparam logic [1:0] REG_TARGET_PERIOD = 2'd2;

  localparam logic [CPU_W-1:0]  CPU_RESET  = 10'd72;
  localparam logic [CPU_W-1:0]  MS_TO_US   = 10'd1000;
  localparam logic [14:0]       LOAD_SCALE = 15'd25600;
  localparam logic [LOAD_W-1:0] LOAD_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic              rec;
    logic              clr;
    logic [STAT_W-1:0] value;
  } lts_upd_t;

  typedef struct packed {
    logic [STAT_W-1:0] min_value;
    logic [STAT_W-1:0] max_value;
    logic [SUM_W-1:0]  sum_value;
    logic [STAT_W-1:0] count_value;
    logic [STAT_W-1:0] last_value;
  } lts_stats_t;

endpackage

`default_nettype wire

// File: rtl/lts_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module lts_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [lts_pkg::SUM_W-1:0]  dividend,
  input  wire logic [lts_pkg::STAT_W-1:0] divisor,
  output logic                            done,
  output logic      [lts_pkg::SUM_W-1:0]  quotient
);
  import lts_pkg::*;

  logic [SUM_W-1:0]     dq;
  logic [STAT_W-1:0]    rem;
  logic [STAT_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;
  logic [STAT_W:0]      rem_sh;
  logic [STAT_W:0]      rem_sub;
  logic                 ge;

  assign rem_sh   = {rem, dq[SUM_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_sub  = rem_sh - {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == {DIV_CNT_W{1'b1}}) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      dq  <= {dq[SUM_W-2:0], ge};
      rem <= ge ? rem_sub[STAT_W-1:0] : rem_sh[STAT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lts_stats.sv
`timescale 1ns / 1ps
`default_nettype none

module lts_stats (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lts_pkg::lts_upd_t   upd,
  output lts_pkg::lts_stats_t      stats
);
  import lts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || upd.clr) begin
      stats.min_value   <= '1;
      stats.max_value   <= '0;
      stats.sum_value   <= '0;
      stats.count_value <= '0;
      stats.last_value  <= '0;
    end else if (upd.rec) begin
      stats.last_value <= upd.value;
      if (upd.value < stats.min_value) begin
        stats.min_value <= upd.value;
      end
      if (upd.value > stats.max_value) begin
        stats.max_value <= upd.value;
      end
      stats.sum_value   <= stats.sum_value + {{(SUM_W-STAT_W){1'b0}}, upd.value};
      stats.count_value <= stats.count_value + STAT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/loop_time_statistics.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Contents
// s_axis    s_axis_tvalid/tready      one item: opcode, start and end stamps
// m_axis    m_axis_tvalid/tready      one result item per input item
// apb       psel/penable/pwrite       cycle_mode @0x0, cycles_per_us @0x4, target @0x8
//
// Each division of an item goes through the one shared restoring divider, up to
// six per item (average, four unit conversions, load).
// rst clears the statistics and loads register defaults.
// A finished result waits in the output register; the next item is taken meanwhile.
module loop_time_statistics (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,   // opcode[1:0], start_stamp[33:2], end_stamp[65:34]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [215:0] m_axis_tdata,   // min_us, avg_us, max_us, last_us, slack_time,
                                            // load_percent[183:160], n_samples[215:184]
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  import lts_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SAMPLE = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_ISSUE  = 6'b001000,
    ST_WAIT   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    JOB_AVG  = 3'd0,
    JOB_MIN  = 3'd1,
    JOB_AVGC = 3'd2,
    JOB_MAX  = 3'd3,
    JOB_LAST = 3'd4,
    JOB_LOAD = 3'd5
  } job_t;

  state_t state, state_next;
  job_t   job, job_next;

  logic              cycle_mode;
  logic [CPU_W-1:0]  cycles_per_us;
  logic [STAT_W-1:0] target_period;

  logic [1:0]        op;
  logic [STAT_W-1:0] diff;
  logic [STAT_W-1:0] sample;
  logic [41:0]       ms_prod;
  logic [46:0]       load_prod;

  logic [STAT_W-1:0] avg_raw;
  logic [STAT_W-1:0] res_min;
  logic [STAT_W-1:0] res_avg;
  logic [STAT_W-1:0] res_max;
  logic [STAT_W-1:0] res_last;
  logic [LOAD_W-1:0] res_load;
  logic [STAT_W-1:0] slack;

  lts_upd_t   upd;
  lts_stats_t stats;

  logic              cnt_nz;
  logic              conv;
  logic [STAT_W-1:0] cpu_div;
  logic              use_div;
  logic [SUM_W-1:0]  div_dividend;
  logic [STAT_W-1:0] div_divisor;
  logic [STAT_W-1:0] direct_val;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;
  logic              res_wr;
  logic [STAT_W-1:0] res_val;
  logic [LOAD_W-1:0] load_sat;
  logic              out_load;
  logic              cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_mode    <= 1'b1;
      cycles_per_us <= CPU_RESET;
      target_period <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CYCLE_MODE:    cycle_mode    <= pwdata[0];
        REG_CYCLES_PER_US: cycles_per_us <= pwdata[CPU_W-1:0];
        REG_TARGET_PERIOD: target_period <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CYCLE_MODE:    prdata = {31'b0, cycle_mode};
      REG_CYCLES_PER_US: prdata = {{(32-CPU_W){1'b0}}, cycles_per_us};
      REG_TARGET_PERIOD: prdata = target_period;
      default:           prdata = '0;
    endcase
  end

  // statistics and shared divider
  assign upd.rec   = (state == ST_UPDATE) && (op == OP_RECORD);
  assign upd.clr   = (state == ST_UPDATE) && (op == OP_CLEAR);
  assign upd.value = sample;

  lts_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .upd   (upd),
    .stats (stats)
  );

  lts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign ms_prod   = {10'b0, diff} * {32'b0, MS_TO_US};
  assign load_prod = {15'b0, res_max} * {32'b0, LOAD_SCALE};
  assign cnt_nz    = stats.count_value != '0;
  assign conv      = cnt_nz && cycle_mode;
  assign cpu_div   = (cycles_per_us == '0) ? 32'd1
                                           : {{(STAT_W-CPU_W){1'b0}}, cycles_per_us};
  assign load_sat  = (quotient[SUM_W-1:LOAD_W] != '0) ? LOAD_MAX : quotient[LOAD_W-1:0];

  // operands of the current job
  always_comb begin
    use_div      = 1'b0;
    div_dividend = '0;
    div_divisor  = cpu_div;
    direct_val   = '0;
    case (job)
      JOB_AVG: begin
        use_div      = cnt_nz;
        div_dividend = stats.sum_value;
        div_divisor  = stats.count_value;
      end
      JOB_MIN: begin
        use_div      = conv;
        div_dividend = {32'b0, stats.min_value};
        direct_val   = cnt_nz ? stats.min_value : '0;
      end
      JOB_AVGC: begin
        use_div      = conv;
        div_dividend = {32'b0, avg_raw};
        direct_val   = cnt_nz ? avg_raw : '0;
      end
      JOB_MAX: begin
        use_div      = conv;
        div_dividend = {32'b0, stats.max_value};
        direct_val   = cnt_nz ? stats.max_value : '0;
      end
      JOB_LAST: begin
        use_div      = conv;
        div_dividend = {32'b0, stats.last_value};
        direct_val   = cnt_nz ? stats.last_value : '0;
      end
      JOB_LOAD: begin
        use_div      = target_period != '0;
        div_dividend = {17'b0, load_prod};
        div_divisor  = target_period;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (job)
      JOB_AVG:  job_next = JOB_MIN;
      JOB_MIN:  job_next = JOB_AVGC;
      JOB_AVGC: job_next = JOB_MAX;
      JOB_MAX:  job_next = JOB_LAST;
      JOB_LAST: job_next = JOB_LOAD;
      default:  job_next = JOB_LOAD;
    endcase
  end

  assign out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    res_wr     = 1'b0;
    res_val    = direct_val;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_SAMPLE;
        end
      end
      ST_SAMPLE: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_ISSUE;
      ST_ISSUE: begin
        if (use_div) begin
          div_start  = 1'b1;
          state_next = ST_WAIT;
        end else begin
          res_wr     = 1'b1;
          state_next = (job == JOB_LOAD) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_WAIT: begin
        if (div_done) begin
          res_wr     = 1'b1;
          res_val    = quotient[STAT_W-1:0];
          state_next = (job == JOB_LOAD) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job   <= JOB_AVG;
    end else begin
      state <= state_next;
      if (state == ST_UPDATE) begin
        job <= JOB_AVG;
      end else if (res_wr) begin
        job <= job_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      op   <= s_axis_tdata[1:0];
      diff <= s_axis_tdata[65:34] - s_axis_tdata[33:2];
    end
    if (state == ST_SAMPLE) begin
      sample <= cycle_mode ? diff : ms_prod[STAT_W-1:0];
    end
    if (res_wr) begin
      case (job)
        JOB_AVG:  avg_raw  <= res_val;
        JOB_MIN:  res_min  <= res_val;
        JOB_AVGC: res_avg  <= res_val;
        JOB_MAX:  res_max  <= res_val;
        JOB_LAST: res_last <= res_val;
        JOB_LOAD: res_load <= (state == ST_WAIT) ? load_sat : '0;
        default: ;
      endcase
    end
  end

  // output register
  assign slack = (target_period != '0 && res_max < target_period)
                 ? target_period - res_max : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {stats.count_value, res_load, slack, res_last,
                       res_max, res_avg, res_min};
    end
  end

endmodule

`default_nettype wire

// File: tb/loop_time_statistics_test.sv
`timescale 1ns / 1ps

module loop_time_statistics_test;
  import lts_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT = 5000;
  localparam int         DRAIN_WAIT  = 500;
  localparam int         PHASE_ITEMS = 92;

  typedef struct packed {
    logic [31:0] end_stamp;
    logic [31:0] start_stamp;
    logic [1:0]  opcode;
  } loop_item_t;

  typedef struct packed {
    logic [31:0] n_samples;
    logic [23:0] load_percent;
    logic [31:0] slack_time;
    logic [31:0] last_us;
    logic [31:0] max_us;
    logic [31:0] avg_us;
    logic [31:0] min_us;
  } loop_report_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;   // opcode[1:0], start_stamp[33:2], end_stamp[65:34]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [215:0] m_axis_tdata;        // min_us, avg_us, max_us, last_us, slack_time,
                                     // load_percent[183:160], n_samples[215:184]
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  loop_time_statistics dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // register copies
  logic             cfg_cycle_mode;
  logic [CPU_W-1:0] cfg_cycles_per_us;
  logic [31:0]      cfg_target;

  // running statistics
  logic [31:0] stat_min;
  logic [31:0] stat_max;
  logic [63:0] stat_sum;
  logic [31:0] stat_count;
  logic [31:0] stat_last;

  loop_item_t   pending_samples[$];
  loop_report_t expected_reports[$];
  loop_item_t   send_item;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           quiet_cycles = 0;
  int           errors = 0;
  bit           idle_on = 1'b1;

  function automatic void clear_stats();
    stat_min   = '1;
    stat_max   = '0;
    stat_sum   = '0;
    stat_count = '0;
    stat_last  = '0;
  endfunction

  function automatic logic [31:0] to_us(logic [31:0] v);
    if (!cfg_cycle_mode) return v;
    return v / (cfg_cycles_per_us == '0 ? 32'd1 : {22'd0, cfg_cycles_per_us});
  endfunction

  function automatic void predict_report(loop_item_t it);
    logic [31:0]  dur;
    logic [63:0]  mean;
    logic [63:0]  load_q;
    loop_report_t rep;
    rep = '0;
    if (it.opcode == OP_RECORD) begin
      dur = it.end_stamp - it.start_stamp;
      if (!cfg_cycle_mode) dur = dur * {22'd0, MS_TO_US};
      stat_last = dur;
      if (dur < stat_min) stat_min = dur;
      if (dur > stat_max) stat_max = dur;
      stat_sum   = stat_sum + {32'd0, dur};
      stat_count = stat_count + 32'd1;
    end else if (it.opcode == OP_CLEAR) begin
      clear_stats();
    end
    if (stat_count != '0) begin
      mean       = stat_sum / {32'd0, stat_count};
      rep.min_us  = to_us(stat_min);
      rep.avg_us  = to_us(mean[31:0]);
      rep.max_us  = to_us(stat_max);
      rep.last_us = to_us(stat_last);
    end
    if (cfg_target != '0) begin
      rep.slack_time = rep.max_us < cfg_target ? cfg_target - rep.max_us : '0;
      load_q = ({32'd0, rep.max_us} * {49'd0, LOAD_SCALE}) / {32'd0, cfg_target};
      rep.load_percent = load_q > {40'd0, LOAD_MAX} ? LOAD_MAX : load_q[23:0];
    end
    rep.n_samples = stat_count;
    expected_reports.push_back(rep);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // sender
  always @(posedge clk) begin : driver
    int gap;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      gap = send_gap;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_report(send_item);
        gap = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold item
      end else if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= gap - 1;
      end else if (pending_samples.size() != 0) begin
        send_item = pending_samples.pop_front();
        s_axis_tdata  <= {6'd0, send_item};
        s_axis_tvalid <= 1'b1;
        send_gap      <= 0;
      end else begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= 0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : monitor
    int           gap;
    loop_report_t got;
    loop_report_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      gap = recv_gap;
      if (m_axis_tvalid && m_axis_tready) begin
        got = loop_report_t'(m_axis_tdata);
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("min_us", want.min_us, got.min_us);
          check_field("avg_us", want.avg_us, got.avg_us);
          check_field("max_us", want.max_us, got.max_us);
          check_field("last_us", want.last_us, got.last_us);
          check_field("slack_time", want.slack_time, got.slack_time);
          check_field("load_percent", {8'd0, want.load_percent}, {8'd0, got.load_percent});
          check_field("n_samples", want.n_samples, got.n_samples);
        end
        gap = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        recv_gap      <= m_axis_tvalid ? gap - 1 : gap;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap      <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CYCLE_MODE:    cfg_cycle_mode    = value[0];
      REG_CYCLES_PER_US: cfg_cycles_per_us = value[CPU_W-1:0];
      REG_TARGET_PERIOD: cfg_target        = value;
      default: ;
    endcase
  endtask

  task automatic set_profile(logic mode, logic [CPU_W-1:0] cpu, logic [31:0] target);
    write_reg(REG_CYCLE_MODE, {31'd0, mode});
    write_reg(REG_CYCLES_PER_US, {22'd0, cpu});
    write_reg(REG_TARGET_PERIOD, target);
  endtask

  task automatic queue_item(logic [1:0] op, logic [31:0] start_stamp, logic [31:0] end_stamp);
    loop_item_t it;
    it.opcode      = op;
    it.start_stamp = start_stamp;
    it.end_stamp   = end_stamp;
    pending_samples.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
  endtask

  function automatic logic [31:0] draw_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2, 3:    return $urandom;
      4, 5, 6: return $urandom_range(0, 4095);
      default: return $urandom_range(1000, 200000);
    endcase
  endfunction

  function automatic logic [31:0] draw_target();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return $urandom_range(1, 5000);
      2:       return $urandom_range(5000, 10_000_000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic             mode;
    logic [CPU_W-1:0] cpu;
    logic [31:0]      target;
    logic [31:0]      start_stamp;
    int               pick;
    logic [1:0]       op;

    cfg_cycle_mode    = 1'b1;
    cfg_cycles_per_us = CPU_RESET;
    cfg_target        = '0;
    clear_stats();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: empty statistics, unused opcode, wrap of stamps
    @(negedge clk);
    queue_item(OP_REPORT, 32'd7, 32'd9);
    queue_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(OP_CLEAR, '0, '0);
    queue_item(OP_RECORD, '0, '0);
    queue_item(OP_RECORD, '0, 32'hFFFF_FFFF);
    queue_item(OP_RECORD, 32'hFFFF_FFFF, '0);
    queue_item(OP_RECORD, 32'd100, 32'd460);
    queue_item(OP_RECORD, 32'd5, 32'd3);
    queue_item(OP_REPORT, '0, '0);
    queue_item(OP_CLEAR, 32'h1234_5678, 32'h8765_4321);
    queue_item(OP_REPORT, '0, '0);
    wait_drained();

    // millisecond mode, product wrap, target on, zero divisor
    set_profile(1'b0, '0, 32'd1000);
    @(negedge clk);
    queue_item(OP_RECORD, '0, 32'd1);
    queue_item(OP_RECORD, 32'd10, 32'd10);
    queue_item(OP_RECORD, '0, 32'd4294968);
    queue_item(OP_UNUSED, '0, '0);
    queue_item(OP_CLEAR, '0, '0);
    queue_item(OP_RECORD, 32'd5, 32'd3);
    wait_drained();
    set_profile(1'b1, '0, 32'd1);
    @(negedge clk);
    queue_item(OP_REPORT, '0, '0);
    queue_item(OP_RECORD, 32'hFFFF_0000, 32'h0000_0100);
    queue_item(OP_CLEAR, '0, '0);
    queue_item(OP_RECORD, 32'd40, 32'd41);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin mode = 1'b1; cpu = 10'd1;    target = 32'hFFFF_FFFF; end
        1: begin mode = 1'b0; cpu = 10'd1023; target = 32'd1;         end
        2: begin mode = 1'b1; cpu = 10'd1023; target = '0;            end
        3: begin mode = 1'b1; cpu = '0;       target = draw_target(); end
        default: begin
          mode   = 1'($urandom_range(0, 1));
          cpu    = CPU_W'($urandom_range(0, 1023));
          target = draw_target();
        end
      endcase
      idle_on = !(p == 1 || p == 5);
      set_profile(mode, cpu, target);
      @(negedge clk);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick        = $urandom_range(0, 19);
        op          = pick < 16 ? OP_RECORD : pick < 18 ? OP_REPORT :
                      pick == 18 ? OP_CLEAR : OP_UNUSED;
        start_stamp = $urandom;
        queue_item(op, start_stamp, start_stamp + draw_duration());
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
